[hdl/efdm_pkg.sv]
// Shared types and constants for the event FIFO with drop marker.
// Used by event_fifo_with_drop_marker; depends on nothing else.
`timescale 1ns / 1ps

package efdm_pkg;

	// Default sizes of the queue and of the item fields.
	localparam int DEPTH_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int ID_BITS_DEF      = 48;

	// Fixed field widths.
	localparam int REQ_W    = 2;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 3;
	localparam int PEND_W   = 32;
	localparam int M_USER_W = STATUS_W + 2;

	// A marker and the event behind it take this many slots.
	localparam int SLOTS_PER_MARKER = 2;

	typedef logic [REQ_W-1:0] req_t;
	localparam req_t REQ_PUSH    = 2'd0;
	localparam req_t REQ_POP     = 2'd1;
	localparam req_t REQ_RELEASE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		STS_PUSHED   = 3'd0,
		STS_MARKER   = 3'd1,
		STS_DROPPED  = 3'd2,
		STS_POPPED   = 3'd3,
		STS_EMPTY    = 3'd4,
		STS_RELEASED = 3'd5,
		STS_REFUSED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH2,
		ST_RDWAIT
	} state_t;

endpackage

[hdl/event_fifo_with_drop_marker.sv]
// Event FIFO with drop marker: queue memory, pointers, drop bookkeeping and result register.
// Depends on efdm_pkg.
`timescale 1ns / 1ps

// Usage:
// Requests enter on the s_ stream: s_tuser carries the request kind (push, pop,
// release), s_tdata the event id, payload and release count. Every request
// except the unused kind gives one result item on the m_ stream.
// The enable register is written through cfg_wen / cfg_wdata, by the user only while the
// block is idle (the block itself does not enforce this); pushes are refused while it is zero.
// Push, drop, refusal, pop of an empty queue and release of nothing show their
// result in the cycle after the item is accepted. A push that first stores a
// marker shows its result the same way, but keeps the block busy in the ST_PUSH2
// state for the second write. A pop or a nonzero release reads the queue memory
// into its registered read data, and the result is loaded from it in ST_RDWAIT.
// No new item is accepted while the block is in ST_PUSH2 or ST_RDWAIT, because of
// the single write port and the registered read port of the queue memory.
// Reset empties the queue, clears the drop counters and the running total, and
// leaves the block disabled. The memory itself is not cleared: only filled
// entries are ever read.
// While a result waits in the output register and m_tready is low, no new item
// is accepted.
module event_fifo_with_drop_marker #(
	parameter int DEPTH        = efdm_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = efdm_pkg::PAYLOAD_BITS_DEF,
	parameter int ID_BITS      = efdm_pkg::ID_BITS_DEF,
	localparam int S_DW = ((ID_BITS + PAYLOAD_BITS + efdm_pkg::COUNT_W + 7) / 8) * 8,
	localparam int M_DW = ((5 * ID_BITS + PAYLOAD_BITS + efdm_pkg::COUNT_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// event_id, event_payload, release_count, zero fill
	input  logic [S_DW-1:0]               s_tdata,
	// req_type
	input  logic [efdm_pkg::REQ_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_id, out_payload, released_count, last_released_id, notify_begin_id,
	// notify_end_id, total_dropped, zero fill
	output logic [M_DW-1:0]               m_tdata,
	// status, out_is_marker, notify_valid
	output logic [efdm_pkg::M_USER_W-1:0] m_tuser
);

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int ENT_W  = 1 + ID_BITS + PAYLOAD_BITS;
	localparam int CMP_W  = (FILL_W > efdm_pkg::COUNT_W) ? FILL_W : efdm_pkg::COUNT_W;
	localparam int SUM_W  = ((PTR_W > efdm_pkg::COUNT_W) ? PTR_W : efdm_pkg::COUNT_W) + 1;
	localparam int TOT_W  = ((ID_BITS > efdm_pkg::PEND_W) ? ID_BITS : efdm_pkg::PEND_W) + 1;
	localparam int CW     = efdm_pkg::COUNT_W;

	// Offsets of the result fields in m_tdata.
	localparam int O_PAY  = ID_BITS;
	localparam int O_RELN = O_PAY + PAYLOAD_BITS;
	localparam int O_LAST = O_RELN + CW;
	localparam int O_NBEG = O_LAST + ID_BITS;
	localparam int O_NEND = O_NBEG + ID_BITS;
	localparam int O_TOT  = O_NEND + ID_BITS;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Queue memory: marker flag, id, payload.
	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rd_data_s1;

	efdm_pkg::state_t state_q, state_d;
	logic                        enabled_q;
	logic [PTR_W-1:0]            head_q, head_d, tail_q, tail_d;
	logic [FILL_W-1:0]           fill_q, fill_d;
	logic [efdm_pkg::PEND_W-1:0] pend_q, pend_d;
	logic [ID_BITS-1:0]          dbeg_q, dbeg_d, total_q, total_d;

	logic [ID_BITS-1:0]      ev_id_q;
	logic [PAYLOAD_BITS-1:0] ev_pay_q;
	logic                    is_pop_q;
	logic [CW-1:0]           rel_n_q;

	logic                    m_tvalid_q;
	logic [M_DW-1:0]         m_tdata_q;
	logic [efdm_pkg::M_USER_W-1:0] m_tuser_q;

	logic                    accept, out_free;
	efdm_pkg::req_t          req;
	logic [ID_BITS-1:0]      in_id;
	logic [PAYLOAD_BITS-1:0] in_pay;
	logic [CW-1:0]           in_k;

	logic [CMP_W-1:0]        n_full;
	logic [CW-1:0]           rel_n;
	logic [SUM_W-1:0]        sum_end, last_raw, last_wrap, head_wrap;
	logic [TOT_W-1:0]        tot_sum;
	logic [ID_BITS-1:0]      tot_sat;
	logic [PAYLOAD_BITS-1:0] mark_cnt;

	logic                    wr_en, rd_en;
	logic [PTR_W-1:0]        wr_addr, rd_addr;
	logic [ENT_W-1:0]        wr_data;

	logic                    load_out;
	efdm_pkg::status_t       res_status;
	logic                    res_marker, res_notify;
	logic [M_DW-1:0]         res_data;

	assign req    = s_tuser;
	assign in_id  = s_tdata[ID_BITS-1:0];
	assign in_pay = s_tdata[ID_BITS +: PAYLOAD_BITS];
	assign in_k   = s_tdata[ID_BITS + PAYLOAD_BITS +: CW];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == efdm_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// Release count clamped to the fill level, and the wrapped indexes it leads to.
	// Both sums stay below twice the depth, so one conditional subtract wraps them.
	assign n_full    = (CMP_W'(in_k) < CMP_W'(fill_q)) ? CMP_W'(in_k) : CMP_W'(fill_q);
	assign rel_n     = CW'(n_full);
	assign sum_end   = SUM_W'(head_q) + SUM_W'(rel_n);
	assign last_raw  = sum_end - SUM_W'(1);
	assign last_wrap = (last_raw >= SUM_W'(DEPTH)) ? last_raw - SUM_W'(DEPTH) : last_raw;
	assign head_wrap = (sum_end >= SUM_W'(DEPTH)) ? sum_end - SUM_W'(DEPTH) : sum_end;

	assign tot_sum  = TOT_W'(total_q) + TOT_W'(pend_q);
	assign tot_sat  = ((tot_sum >> ID_BITS) != '0) ? '1 : ID_BITS'(tot_sum);
	assign mark_cnt = ((pend_q >> PAYLOAD_BITS) != '0) ? '1 : PAYLOAD_BITS'(pend_q);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		pend_d     = pend_q;
		dbeg_d     = dbeg_q;
		total_d    = total_q;
		wr_en      = 1'b0;
		wr_addr    = tail_q;
		wr_data    = {1'b0, in_id, in_pay};
		rd_en      = 1'b0;
		rd_addr    = head_q;
		load_out   = 1'b0;
		res_status = efdm_pkg::STS_PUSHED;
		res_marker = 1'b0;
		res_notify = 1'b0;
		res_data   = '0;
		unique case (state_q)
			efdm_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req)
						efdm_pkg::REQ_PUSH: begin
							load_out = 1'b1;
							if (!enabled_q) begin
								res_status = efdm_pkg::STS_REFUSED;
							end else if (pend_q != '0) begin
								if (fill_q > FILL_W'(DEPTH - efdm_pkg::SLOTS_PER_MARKER)) begin
									if (pend_q != '1) begin
										pend_d = pend_q + 1'b1;
									end
									res_status = efdm_pkg::STS_DROPPED;
								end else begin
									// Marker goes in now, the event itself next cycle.
									wr_en      = 1'b1;
									wr_data    = {1'b1, dbeg_q, mark_cnt};
									tail_d     = ptr_next(tail_q);
									fill_d     = fill_q + FILL_W'(efdm_pkg::SLOTS_PER_MARKER);
									total_d    = tot_sat;
									pend_d     = '0;
									res_status = efdm_pkg::STS_MARKER;
									res_notify = 1'b1;
									res_data[O_NBEG +: ID_BITS] = dbeg_q;
									res_data[O_NEND +: ID_BITS] = in_id - 1'b1;
									state_d    = efdm_pkg::ST_PUSH2;
								end
							end else if (fill_q == FILL_W'(DEPTH)) begin
								dbeg_d     = in_id;
								pend_d     = efdm_pkg::PEND_W'(1);
								res_status = efdm_pkg::STS_DROPPED;
							end else begin
								wr_en      = 1'b1;
								tail_d     = ptr_next(tail_q);
								fill_d     = fill_q + 1'b1;
								res_status = efdm_pkg::STS_PUSHED;
							end
						end
						efdm_pkg::REQ_POP: begin
							if (fill_q == '0) begin
								load_out   = 1'b1;
								res_status = efdm_pkg::STS_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								head_d  = ptr_next(head_q);
								fill_d  = fill_q - 1'b1;
								state_d = efdm_pkg::ST_RDWAIT;
							end
						end
						efdm_pkg::REQ_RELEASE: begin
							if (rel_n == '0) begin
								load_out   = 1'b1;
								res_status = efdm_pkg::STS_RELEASED;
							end else begin
								rd_en   = 1'b1;
								rd_addr = PTR_W'(last_wrap);
								head_d  = PTR_W'(head_wrap);
								fill_d  = fill_q - FILL_W'(rel_n);
								state_d = efdm_pkg::ST_RDWAIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			efdm_pkg::ST_PUSH2: begin
				wr_en   = 1'b1;
				wr_addr = tail_q;
				wr_data = {1'b0, ev_id_q, ev_pay_q};
				tail_d  = ptr_next(tail_q);
				state_d = efdm_pkg::ST_IDLE;
			end
			efdm_pkg::ST_RDWAIT: begin
				// The output register was emptied when the item was accepted.
				load_out = 1'b1;
				if (is_pop_q) begin
					res_status = efdm_pkg::STS_POPPED;
					res_marker = rd_data_s1[ENT_W-1];
					res_data[ID_BITS-1:0]          = rd_data_s1[PAYLOAD_BITS +: ID_BITS];
					res_data[O_PAY +: PAYLOAD_BITS] = rd_data_s1[PAYLOAD_BITS-1:0];
				end else begin
					res_status = efdm_pkg::STS_RELEASED;
					res_data[O_RELN +: CW]      = rel_n_q;
					res_data[O_LAST +: ID_BITS] = rd_data_s1[PAYLOAD_BITS +: ID_BITS];
				end
				state_d = efdm_pkg::ST_IDLE;
			end
			default: begin
				state_d = efdm_pkg::ST_IDLE;
			end
		endcase
		res_data[O_TOT +: ID_BITS] = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			pend_q     <= '0;
			dbeg_q     <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				enabled_q <= cfg_wdata;
			end
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			pend_q  <= pend_d;
			dbeg_q  <= dbeg_d;
			total_q <= total_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_id_q  <= in_id;
			ev_pay_q <= in_pay;
			is_pop_q <= (req == efdm_pkg::REQ_POP);
			rel_n_q  <= rel_n;
		end
		if (load_out) begin
			m_tdata_q <= res_data;
			m_tuser_q <= {res_notify, res_marker, res_status};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
